/* hdl/mmie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmie_pkg
// Shared types and constants of the memory-to-memory instruction executor.
// ----------------------------------------------------------------------------
package mmie_pkg;

   localparam int WORD_W        = 32;
   localparam int POS_W         = 12;
   localparam int OP_W          = 5;
   localparam int DEST_W        = 12;
   localparam int SRCB_W        = 7;
   localparam int DATA_WORDS_DEF  = 128;
   localparam int STACK_DEPTH_DEF = 1024;

   typedef enum logic [OP_W-1:0] {
      OP_ADD    = 5'd0,
      OP_MUL    = 5'd1,
      OP_SUB    = 5'd2,
      OP_DIV    = 5'd3,
      OP_COPY   = 5'd4,
      OP_LDI    = 5'd5,
      OP_JMP    = 5'd6,
      OP_CALL   = 5'd7,
      OP_JZ     = 5'd8,
      OP_LT     = 5'd9,
      OP_GT     = 5'd10,
      OP_EQ     = 5'd11,
      OP_PRINT  = 5'd12,
      OP_STAUX  = 5'd13,
      OP_LDAUX  = 5'd14,
      OP_POP    = 5'd15,
      OP_PUSH   = 5'd16,
      OP_RET    = 5'd17,
      OP_PUSHLR = 5'd18
   } op_type;

endpackage

/* hdl/mmie_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmie_if
// Valid/ready channels carrying instruction items and result items.
// ----------------------------------------------------------------------------
interface mmie_req_if;
   logic        valid;
   logic        ready;
   logic [4:0]  operation;
   logic [11:0] dest_or_target;
   logic signed [31:0] operand_a;
   logic [6:0]  operand_b;

   modport source  (output valid, output operation, output dest_or_target,
                    output operand_a, output operand_b, input ready);
   modport sink    (input valid, input operation, input dest_or_target,
                    input operand_a, input operand_b, output ready);
   modport monitor (input valid, input operation, input dest_or_target,
                    input operand_a, input operand_b, input ready);
endinterface

interface mmie_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] next_position;
   logic        print_valid;
   logic signed [31:0] print_value;
   logic        divide_error;

   modport source  (output valid, output next_position, output print_valid,
                    output print_value, output divide_error, input ready);
   modport sink    (input valid, input next_position, input print_valid,
                    input print_value, input divide_error, output ready);
   modport monitor (input valid, input next_position, input print_valid,
                    input print_value, input divide_error, input ready);
endinterface

/* hdl/memory_to_memory_instruction_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_to_memory_instruction_executor
// Sequence: an accepted item passes through the read, execute and write-back
// states; a divide with nonzero divisor also waits in S_DV (bit-serial divider).
// Items: only one is in flight; the next is accepted after the write-back on
// the single-ported data memory write path, which waits for rsp.ready.
// Reset: a clearing pass writes zero to all DATA_WORDS data words, one per
// cycle; no item is accepted until it ends. Position resets to 1.
// ----------------------------------------------------------------------------
module memory_to_memory_instruction_executor
   import mmie_pkg::*;
#(
   parameter int DATA_WORDS  = DATA_WORDS_DEF,
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   mmie_req_if.sink    req,
   mmie_rsp_if.source  rsp
);

   localparam int AW = $clog2(DATA_WORDS);
   localparam int SW = $clog2(STACK_DEPTH);

   typedef enum logic [5:0] {
      S_CLR  = 6'b000001,
      S_IDLE = 6'b000010,
      S_RD   = 6'b000100,
      S_EX   = 6'b001000,
      S_DV   = 6'b010000,
      S_WB   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [DEST_W-1:0] d_ff, d_in;
   logic [WORD_W-1:0] a_ff, a_in;
   logic [SRCB_W-1:0] b_ff, b_in;
   logic [SW-1:0]     sp_ff, sp_in;
   logic [WORD_W-1:0] link_ff, link_in;
   logic [WORD_W-1:0] aux_ff, aux_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  next_ff, next_in;
   logic [WORD_W-1:0] res_ff, res_in;
   logic              derr_ff, derr_in;
   logic              neg_ff, neg_in;
   logic              ok0_ff, ok0_in;
   logic              ok1_ff, ok1_in;
   logic              rv_ff, rv_in;
   logic [POS_W-1:0]  rpos_ff, rpos_in;
   logic              rpv_ff, rpv_in;
   logic [WORD_W-1:0] rval_ff, rval_in;
   logic              rderr_ff, rderr_in;

   logic              use_d;
   logic [SW-1:0]     sp_inc, sp_dec;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WORD_W-1:0] rdata0, rdata1, sdata;
   logic [WORD_W-1:0] x, y;
   logic              stk_we;
   logic              div_start, div_done;
   logic [WORD_W-1:0] div_q;
   logic              d_ok;
   logic              is_write;
   op_type            op;

   assign op     = op_type'(op_ff);
   assign use_d  = op_ff inside {OP_JZ, OP_PRINT, OP_STAUX, OP_PUSH};
   assign sp_inc = (sp_ff == SW'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
   assign sp_dec = (sp_ff == '0) ? SW'(STACK_DEPTH - 1) : sp_ff - 1'b1;
   assign x      = ok0_ff ? rdata0 : '0;
   assign y      = ok1_ff ? rdata1 : '0;
   assign d_ok   = 32'(d_ff) < 32'(DATA_WORDS);
   assign is_write = op_ff inside {OP_ADD, OP_MUL, OP_SUB, OP_DIV, OP_COPY, OP_LDI,
                                   OP_LT, OP_GT, OP_EQ, OP_LDAUX, OP_POP};

   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(d_ff);
      mem_wdata = res_ff;
      stk_we    = 1'b0;
      if (state_ff == S_CLR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = '0;
      end else if (state_ff == S_WB && !(rv_ff && !rsp.ready)) begin
         mem_we = is_write && d_ok;
         stk_we = (op_ff == OP_PUSH) || (op_ff == OP_PUSHLR);
      end
   end

   mmie_data_mem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
      .clock  (clock),
      .we     (mem_we),
      .waddr  (mem_waddr),
      .wdata  (mem_wdata),
      .raddr0 (use_d ? AW'(d_ff) : AW'(a_ff)),
      .raddr1 (AW'(b_ff)),
      .rdata0 (rdata0),
      .rdata1 (rdata1)
   );

   mmie_stack_mem #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (sp_ff),
      .wdata (res_ff),
      .raddr (sp_dec),
      .rdata (sdata)
   );

   mmie_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (x[WORD_W-1] ? -x : x),
      .denom (y[WORD_W-1] ? -y : y),
      .done  (div_done),
      .quot  (div_q)
   );

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      op_in     = op_ff;
      d_in      = d_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      sp_in     = sp_ff;
      link_in   = link_ff;
      aux_in    = aux_ff;
      pos_in    = pos_ff;
      next_in   = next_ff;
      res_in    = res_ff;
      derr_in   = derr_ff;
      neg_in    = neg_ff;
      ok0_in    = ok0_ff;
      ok1_in    = ok1_ff;
      rv_in     = rv_ff && !rsp.ready;
      rpos_in   = rpos_ff;
      rpv_in    = rpv_ff;
      rval_in   = rval_ff;
      rderr_in  = rderr_ff;
      div_start = 1'b0;
      case (state_ff)
         S_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DATA_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               op_in    = req.operation;
               d_in     = req.dest_or_target;
               a_in     = req.operand_a;
               b_in     = req.operand_b;
               state_in = S_RD;
            end
         end
         S_RD: begin
            ok0_in   = use_d ? d_ok : (a_ff < 32'(DATA_WORDS));
            ok1_in   = 32'(b_ff) < 32'(DATA_WORDS);
            state_in = S_EX;
         end
         S_EX: begin
            next_in  = pos_ff + 1'b1;
            res_in   = '0;
            derr_in  = 1'b0;
            neg_in   = x[WORD_W-1] ^ y[WORD_W-1];
            state_in = S_WB;
            case (op)
               OP_ADD:   res_in = x + y;
               OP_MUL:   res_in = WORD_W'(x * y);
               OP_SUB:   res_in = x - y;
               OP_DIV: begin
                  if (y == '0) begin
                     derr_in = 1'b1;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DV;
                  end
               end
               OP_COPY:  res_in = x;
               OP_LDI:   res_in = a_ff;
               OP_JMP:   next_in = d_ff;
               OP_CALL:  next_in = d_ff;
               OP_JZ: begin
                  if (x == '0) begin
                     next_in = a_ff[POS_W-1:0];
                  end
               end
               OP_LT:    res_in = WORD_W'($signed(x) < $signed(y));
               OP_GT:    res_in = WORD_W'($signed(y) < $signed(x));
               OP_EQ:    res_in = WORD_W'(x == y);
               OP_PRINT: res_in = x;
               OP_STAUX: res_in = x;
               OP_LDAUX: res_in = aux_ff;
               OP_POP:   res_in = sdata;
               OP_PUSH:  res_in = x;
               OP_RET:   next_in = sdata[POS_W-1:0];
               OP_PUSHLR: res_in = link_ff;
               default:  res_in = '0;
            endcase
         end
         S_DV: begin
            if (div_done) begin
               res_in   = neg_ff ? -div_q : div_q;
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (!(rv_ff && !rsp.ready)) begin
               if (op_ff == OP_CALL) begin
                  // position after the call, wrapped to POS_W bits
                  link_in = {{(WORD_W-POS_W){1'b0}}, pos_ff + 1'b1};
               end
               if (op_ff == OP_STAUX) begin
                  aux_in = res_ff;
               end
               if (op_ff == OP_POP || op_ff == OP_RET) begin
                  sp_in = sp_dec;
               end
               if (op_ff == OP_PUSH || op_ff == OP_PUSHLR) begin
                  sp_in = sp_inc;
               end
               pos_in   = next_ff;
               rv_in    = 1'b1;
               rpos_in  = next_ff;
               rpv_in   = (op_ff == OP_PRINT);
               rval_in  = (op_ff == OP_PRINT) ? res_ff : '0;
               rderr_in = derr_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff   <= '0;
         sp_ff    <= '0;
         link_ff  <= '0;
         aux_ff   <= '0;
         pos_ff   <= POS_W'(1);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sp_ff    <= sp_in;
         link_ff  <= link_in;
         aux_ff   <= aux_in;
         pos_ff   <= pos_in;
         rv_ff    <= rv_in;
      end
      op_ff    <= op_in;
      d_ff     <= d_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      next_ff  <= next_in;
      res_ff   <= res_in;
      derr_ff  <= derr_in;
      neg_ff   <= neg_in;
      ok0_ff   <= ok0_in;
      ok1_ff   <= ok1_in;
      rpos_ff  <= rpos_in;
      rpv_ff   <= rpv_in;
      rval_ff  <= rval_in;
      rderr_ff <= rderr_in;
   end

   assign rsp.valid         = rv_ff;
   assign rsp.next_position = rpos_ff;
   assign rsp.print_valid   = rpv_ff;
   assign rsp.print_value   = rval_ff;
   assign rsp.divide_error  = rderr_ff;

endmodule

/* hdl/mmie_data_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmie_data_mem
// Data word memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mmie_data_mem
   import mmie_pkg::*;
#(
   parameter int DATA_WORDS = DATA_WORDS_DEF,
   localparam int AW = $clog2(DATA_WORDS)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic [WORD_W-1:0] wdata,
   input  logic [AW-1:0]     raddr0,
   input  logic [AW-1:0]     raddr1,
   output logic [WORD_W-1:0] rdata0,
   output logic [WORD_W-1:0] rdata1
);

   logic [WORD_W-1:0] mem [DATA_WORDS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
   end

endmodule

/* hdl/mmie_stack_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmie_stack_mem
// Call stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mmie_stack_mem
   import mmie_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   localparam int SW = $clog2(STACK_DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [SW-1:0]     waddr,
   input  logic [WORD_W-1:0] wdata,
   input  logic [SW-1:0]     raddr,
   output logic [WORD_W-1:0] rdata
);

   logic [WORD_W-1:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

/* hdl/mmie_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmie_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmie_divider
   import mmie_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] numer,
   input  logic [WORD_W-1:0] denom,
   output logic              done,
   output logic [WORD_W-1:0] quot
);

   localparam int CW = $clog2(WORD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] q_ff, q_in;
   logic [WORD_W-1:0] den_ff, den_in;
   logic [WORD_W:0]   sh;
   logic [WORD_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      sh      = {rem_ff, q_ff[WORD_W-1]};
      diff    = sh - {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            q_in   = {q_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = sh[WORD_W-1:0];
            q_in   = {q_ff[WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
